// ===== hw/rtl/pcmsep_pkg.sv =====
`default_nettype none

package pcmsep_pkg;

	localparam int MaxChannels = 8;
	localparam int ShiftBits   = 6;
	localparam int ChanBits    = $clog2(MaxChannels);

	localparam int SampleBits  = 64;
	localparam int OutBits     = 32;
	localparam int CountBits   = 3;
	localparam int ShiftsBits  = MaxChannels * ShiftBits;
	localparam int CfgDataBits = ShiftsBits;
	localparam int CfgIdxBits  = 3;

	// Register indexes on the configuration channel.
	localparam logic [CfgIdxBits-1:0] REG_SAMPLE_WIDTH     = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_UNSIGNED_SAMPLES = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_BIG_ENDIAN       = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_CHANNEL_COUNT    = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_CHANNEL_SHIFTS   = 3'd4;

	// Output width codes.
	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_24 = 2'd2;
	localparam logic [1:0] WIDTH_32 = 2'd3;

	localparam logic signed [SampleBits-1:0] LIM_8  = 64'sh0000_0000_0000_007F;
	localparam logic signed [SampleBits-1:0] LIM_16 = 64'sh0000_0000_0000_7FFF;
	localparam logic signed [SampleBits-1:0] LIM_24 = 64'sh0000_0000_007F_FFFF;
	localparam logic signed [SampleBits-1:0] LIM_32 = 64'sh0000_0000_7FFF_FFFF;

	localparam logic [7:0]  SIGN_8  = 8'h80;
	localparam logic [15:0] SIGN_16 = 16'h8000;
	localparam logic [23:0] SIGN_24 = 24'h80_0000;
	localparam logic [31:0] SIGN_32 = 32'h8000_0000;

	// Output format settings seen by the conversion logic.
	typedef struct packed {
		logic [1:0] sample_width;
		logic       unsigned_samples;
		logic       big_endian;
	} fmt_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcmsep_convert.sv =====
`default_nettype none

module pcmsep_convert (
	input  wire pcmsep_pkg::fmt_cfg_t                         fmt,
	input  wire logic signed [pcmsep_pkg::SampleBits-1:0]     sample,
	input  wire logic [pcmsep_pkg::ShiftBits-1:0]             shift,
	output logic [pcmsep_pkg::OutBits-1:0]                    out_bytes,
	output logic [pcmsep_pkg::CountBits-1:0]                  byte_count
);
	import pcmsep_pkg::*;

	logic signed [SampleBits-1:0] shifted;
	logic signed [SampleBits-1:0] lim;
	logic signed [SampleBits-1:0] neg_lim;
	logic signed [SampleBits-1:0] clamped;
	logic [7:0]  w8;
	logic [15:0] w16;
	logic [23:0] w24;
	logic [31:0] w32;

	assign shifted = sample >>> shift;

	always_comb begin
		case (fmt.sample_width)
			WIDTH_8:  lim = LIM_8;
			WIDTH_16: lim = LIM_16;
			WIDTH_24: lim = LIM_24;
			default:  lim = LIM_32;
		endcase
	end

	assign neg_lim = -lim;

	// Symmetric clamp; the most negative input lands on the negative limit.
	always_comb begin
		if (shifted > lim) begin
			clamped = lim;
		end else if (shifted < neg_lim) begin
			clamped = neg_lim;
		end else begin
			clamped = shifted;
		end
	end

	assign w8  = clamped[7:0]  ^ (fmt.unsigned_samples ? SIGN_8  : 8'h00);
	assign w16 = clamped[15:0] ^ (fmt.unsigned_samples ? SIGN_16 : 16'h0000);
	assign w24 = clamped[23:0] ^ (fmt.unsigned_samples ? SIGN_24 : 24'h00_0000);
	assign w32 = clamped[31:0] ^ (fmt.unsigned_samples ? SIGN_32 : 32'h0000_0000);

	always_comb begin
		case (fmt.sample_width)
			WIDTH_8: begin
				out_bytes  = {24'h00_0000, w8};
				byte_count = 3'd1;
			end
			WIDTH_16: begin
				out_bytes  = fmt.big_endian ? {16'h0000, w16[7:0], w16[15:8]}
				                            : {16'h0000, w16};
				byte_count = 3'd2;
			end
			WIDTH_24: begin
				out_bytes  = fmt.big_endian ? {8'h00, w24[7:0], w24[15:8], w24[23:16]}
				                            : {8'h00, w24};
				byte_count = 3'd3;
			end
			default: begin
				out_bytes  = fmt.big_endian ? {w32[7:0], w32[15:8], w32[23:16], w32[31:24]}
				                            : w32;
				byte_count = 3'd4;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pcm_sample_export_packer.sv =====
`default_nettype none

// Channel   Direction  Beat content
// s_*       in         tdata[63:0] sample; tuser[0] start_of_buffer
// m_*       out        tdata[31:0] out_bytes; tuser[2:0] byte_count, [5:3] channel_index
// cfg_*     in         cfg_index register index; cfg_data write value (always ready)
//
// One beat per cycle while m_tready is high; m_tvalid rises once a sample has reached stage 2.
// Stage 1 holds the sample with its channel and shift, stage 2 holds the packed result;
// the barrel shift, clamp and byte swap between them set the cycle time.
// Reset clears the pipeline, restores the register defaults and restarts at channel 0.
// A stall on m_tready backs up through both stages, so s_tready drops only when full.

module pcm_sample_export_packer (
	input  wire  logic                                    clk,
	input  wire  logic                                    arst_n,
	input  wire  logic                                    s_tvalid,
	output logic                                          s_tready,
	input  wire  logic [pcmsep_pkg::SampleBits-1:0]       s_tdata,  // [63:0] sample
	input  wire  logic [0:0]                              s_tuser,  // [0] start_of_buffer
	output logic                                          m_tvalid,
	input  wire  logic                                    m_tready,
	output logic [pcmsep_pkg::OutBits-1:0]                m_tdata,  // [31:0] out_bytes
	output logic [5:0]                                    m_tuser,  // [2:0] byte_count,
	                                                                // [5:3] channel_index
	input  wire  logic                                    cfg_valid,
	output logic                                          cfg_ready,
	input  wire  logic [pcmsep_pkg::CfgIdxBits-1:0]       cfg_index,
	input  wire  logic [pcmsep_pkg::CfgDataBits-1:0]      cfg_data
);
	import pcmsep_pkg::*;

	fmt_cfg_t               fmt_q;
	logic [3:0]             channel_count_q;
	logic [ShiftsBits-1:0]  channel_shifts_q;
	logic [ChanBits-1:0]    next_channel_q;

	logic [3:0]             eff_count;
	logic [ChanBits-1:0]    ch;
	logic [ChanBits:0]      ch_inc;
	logic [ChanBits-1:0]    ch_next;
	logic                   s_accept;
	logic                   adv_s1;

	logic                           valid_s1;
	logic signed [SampleBits-1:0]   sample_s1;
	logic [ShiftBits-1:0]           shift_s1;
	logic [ChanBits-1:0]            ch_s1;

	logic                           valid_s2;
	logic [OutBits-1:0]             bytes_s2;
	logic [CountBits-1:0]           count_s2;
	logic [ChanBits-1:0]            ch_s2;

	logic [OutBits-1:0]             conv_bytes;
	logic [CountBits-1:0]           conv_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q.sample_width     <= WIDTH_16;
			fmt_q.unsigned_samples <= 1'b0;
			fmt_q.big_endian       <= 1'b0;
			channel_count_q        <= 4'd2;
			channel_shifts_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAMPLE_WIDTH:     fmt_q.sample_width     <= cfg_data[1:0];
				REG_UNSIGNED_SAMPLES: fmt_q.unsigned_samples <= cfg_data[0];
				REG_BIG_ENDIAN:       fmt_q.big_endian       <= cfg_data[0];
				REG_CHANNEL_COUNT:    channel_count_q        <= cfg_data[3:0];
				REG_CHANNEL_SHIFTS:   channel_shifts_q       <= cfg_data[ShiftsBits-1:0];
				default: begin
				end
			endcase
		end
	end

	// A count of zero or above the maximum runs all channels.
	assign eff_count = (channel_count_q == 4'd0 || channel_count_q > 4'(MaxChannels))
	                   ? 4'(MaxChannels) : channel_count_q;

	// A stale index left above a lowered count falls back to channel 0.
	always_comb begin
		ch = s_tuser[0] ? '0 : next_channel_q;
		if (4'(ch) >= eff_count) begin
			ch = '0;
		end
	end

	assign ch_inc  = {1'b0, ch} + 1'b1;
	assign ch_next = (4'(ch_inc) >= eff_count) ? '0 : ch_inc[ChanBits-1:0];

	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_channel_q <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
		end else begin
			if (s_accept) begin
				next_channel_q <= ch_next;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_s1 <= s_tdata;
			shift_s1  <= channel_shifts_q[ShiftBits*ch +: ShiftBits];
			ch_s1     <= ch;
		end
		if (adv_s1 && valid_s1) begin
			bytes_s2 <= conv_bytes;
			count_s2 <= conv_count;
			ch_s2    <= ch_s1;
		end
	end

	pcmsep_convert u_convert (
		.fmt        (fmt_q),
		.sample     (sample_s1),
		.shift      (shift_s1),
		.out_bytes  (conv_bytes),
		.byte_count (conv_count)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = bytes_s2;
	assign m_tuser  = {ch_s2, count_s2};

endmodule

`default_nettype wire

// ===== tb/sv/tb_pcm_sample_export_packer.sv =====
`timescale 1ns / 100ps

module tb_pcm_sample_export_packer;
	import pcmsep_pkg::*;

	localparam int PIPE_LATENCY   = 2;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_BLOCKS    = 13;
	localparam int BLOCK_ITEMS    = 100;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [CfgIdxBits-1:0] REG_UNUSED = 3'd7;

	localparam logic signed [SampleBits-1:0] SMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SampleBits-1:0] SMP_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [OutBits-1:0]   packed_bytes;
		logic [CountBits-1:0] byte_count;
		logic [ChanBits-1:0]  chan;
	} pcm_word_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		logic [CfgIdxBits-1:0]        reg_idx;
		logic [CfgDataBits-1:0]       reg_val;
		logic signed [SampleBits-1:0] smp;
		logic                         sob;
		logic                         has_exp;
		pcm_word_t                    exp_word;
	} stim_row_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [SampleBits-1:0]   s_tdata   = '0;
	logic [0:0]              s_tuser   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OutBits-1:0]      m_tdata;
	logic [5:0]              m_tuser;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CfgIdxBits-1:0]   cfg_index = '0;
	logic [CfgDataBits-1:0]  cfg_data  = '0;

	// Local copy of the format registers and the channel rotation.
	logic [1:0]              fmt_width;
	logic                    fmt_unsigned;
	logic                    fmt_big_endian;
	logic [3:0]              chan_count;
	logic [ShiftsBits-1:0]   chan_shifts;
	logic [ChanBits-1:0]     chan_next;

	pcm_word_t pending_words[$];
	stim_row_t stim_rows[$];
	int        mismatches  = 0;
	int        idle_pct    = 0;
	int        stall_pct   = 0;
	int        idle_cycles = 0;

	pcm_sample_export_packer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic pcm_word_t pack_pcm_word(input logic signed [SampleBits-1:0] smp,
			input logic sob);
		int                           cnt;
		int                           ch;
		int                           nxt;
		int                           nbytes;
		int                           wbits;
		logic signed [SampleBits-1:0] v;
		logic signed [SampleBits-1:0] lim;
		logic [OutBits-1:0]           word;
		logic [OutBits-1:0]           swapped;
		pcm_word_t                    res;

		cnt = (chan_count == 0 || chan_count > MaxChannels) ? MaxChannels : int'(chan_count);
		ch = sob ? 0 : int'(chan_next);
		// A count lowered below the pending channel sends the rotation back to 0.
		if (ch >= cnt)
			ch = 0;
		nxt = ch + 1;
		if (nxt >= cnt)
			nxt = 0;
		chan_next = nxt[ChanBits-1:0];

		v = smp >>> chan_shifts[ShiftBits*ch +: ShiftBits];
		nbytes = int'(fmt_width) + 1;
		wbits = 8 * nbytes;
		lim = (64'sd1 <<< (wbits - 1)) - 64'sd1;
		// Symmetric clamp, so the most negative code never appears.
		if (v > lim)
			v = lim;
		else if (v < -lim)
			v = -lim;

		word = v[OutBits-1:0] & OutBits'((64'd1 << wbits) - 64'd1);
		if (fmt_unsigned)
			word[wbits-1] = ~word[wbits-1];

		if (fmt_big_endian && nbytes > 1) begin
			swapped = '0;
			for (int i = 0; i < nbytes; i++)
				swapped[8*i +: 8] = word[8*(nbytes-1-i) +: 8];
			word = swapped;
		end

		res.packed_bytes = word;
		res.byte_count   = nbytes[CountBits-1:0];
		res.chan         = ch[ChanBits-1:0];
		return res;
	endfunction

	function automatic logic [CfgDataBits-1:0] rand_cfg();
		logic [63:0] r;

		r = {$urandom, $urandom};
		return r[CfgDataBits-1:0];
	endfunction

	// Mostly values of a random bit length, so that both clamped and passed values occur.
	function automatic logic signed [SampleBits-1:0] rand_sample();
		logic signed [SampleBits-1:0] raw;

		raw = {$urandom, $urandom};
		case ($urandom_range(15))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			3: return -64'sd1;
			default: return raw >>> (63 - $urandom_range(63));
		endcase
	endfunction

	function automatic void add_write(input logic [CfgIdxBits-1:0] idx,
			input logic [CfgDataBits-1:0] val);
		stim_row_t row;

		row = '{kind: ROW_WRITE, reg_idx: idx, reg_val: val, smp: '0, sob: 1'b0,
			has_exp: 1'b0, exp_word: '0};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_sample(input logic signed [SampleBits-1:0] smp, input logic sob);
		stim_row_t row;

		row = '{kind: ROW_SAMPLE, reg_idx: '0, reg_val: '0, smp: smp, sob: sob,
			has_exp: 1'b0, exp_word: '0};
		stim_rows.push_back(row);
	endfunction

	function automatic void add_checked(input logic signed [SampleBits-1:0] smp, input logic sob,
			input logic [OutBits-1:0] bytes_exp, input int nb, input int ch);
		stim_row_t row;

		row = '{kind: ROW_SAMPLE, reg_idx: '0, reg_val: '0, smp: smp, sob: sob,
			has_exp: 1'b1, exp_word: '{bytes_exp, nb[CountBits-1:0], ch[ChanBits-1:0]}};
		stim_rows.push_back(row);
	endfunction

	task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_SAMPLE_WIDTH:     fmt_width      = val[1:0];
			REG_UNSIGNED_SAMPLES: fmt_unsigned   = val[0];
			REG_BIG_ENDIAN:       fmt_big_endian = val[0];
			REG_CHANNEL_COUNT:    chan_count     = val[3:0];
			REG_CHANNEL_SHIFTS:   chan_shifts    = val[ShiftsBits-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SampleBits-1:0] smp, input logic sob,
			input logic has_exp, input pcm_word_t exp_word);
		pcm_word_t w;

		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= sob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		w = pack_pcm_word(smp, sob);
		pending_words.push_back(has_exp ? exp_word : w);
	endtask

	// Stop sending and let the pipeline empty before registers change.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		pcm_word_t got;
		pcm_word_t want;

		if (arst_n && m_tvalid && m_tready) begin
			got.packed_bytes = m_tdata;
			got.byte_count   = m_tuser[2:0];
			got.chan         = m_tuser[5:3];
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: bytes=%h count=%0d chan=%0d",
						got.packed_bytes, got.byte_count, got.chan);
			end else begin
				want = pending_words.pop_front();
				if (got.packed_bytes !== want.packed_bytes ||
						got.byte_count !== want.byte_count ||
						got.chan !== want.chan) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"mismatch: expected bytes=%h count=%0d chan=%0d,",
							" got bytes=%h count=%0d chan=%0d"},
							want.packed_bytes, want.byte_count, want.chan,
							got.packed_bytes, got.byte_count, got.chan);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [CfgDataBits-1:0] val;

		fmt_width      = WIDTH_16;
		fmt_unsigned   = 1'b0;
		fmt_big_endian = 1'b0;
		chan_count     = 4'd2;
		chan_shifts    = '0;
		chan_next      = '0;

		// Reset format: 16-bit signed little endian, two channels, no shifts.
		add_checked(64'sd0,    1'b0, 32'h0000_0000, 2, 0);
		add_checked(SMP_MAX,   1'b0, 32'h0000_7FFF, 2, 1);
		add_checked(SMP_MIN,   1'b0, 32'h0000_8001, 2, 0);
		add_checked(-64'sd1,   1'b1, 32'h0000_FFFF, 2, 0);
		add_checked(-64'sd32768, 1'b0, 32'h0000_8001, 2, 1);
		// 8-bit offset binary.
		add_write(REG_SAMPLE_WIDTH, {46'd0, WIDTH_8});
		add_write(REG_UNSIGNED_SAMPLES, 48'd1);
		add_checked(64'sd0,    1'b1, 32'h0000_0080, 1, 0);
		add_checked(SMP_MAX,   1'b0, 32'h0000_00FF, 1, 1);
		add_checked(SMP_MIN,   1'b0, 32'h0000_0001, 1, 0);
		// 32-bit and 24-bit big endian.
		add_write(REG_SAMPLE_WIDTH, {46'd0, WIDTH_32});
		add_write(REG_UNSIGNED_SAMPLES, 48'd0);
		add_write(REG_BIG_ENDIAN, 48'd1);
		add_checked(64'sh1234_5678, 1'b1, 32'h7856_3412, 4, 0);
		add_checked(SMP_MIN,   1'b0, 32'h0100_0080, 4, 1);
		add_write(REG_SAMPLE_WIDTH, {46'd0, WIDTH_24});
		add_checked(64'sh12_3456, 1'b1, 32'h0056_3412, 3, 0);
		add_checked(SMP_MAX,   1'b0, 32'h00FF_FF7F, 3, 1);
		// A zero count acts as eight channels; every shift at its maximum.
		add_write(REG_BIG_ENDIAN, 48'd0);
		add_write(REG_CHANNEL_COUNT, 48'd0);
		add_write(REG_CHANNEL_SHIFTS, 48'hFFFF_FFFF_FFFF);
		add_sample(SMP_MIN, 1'b1);
		add_sample(SMP_MAX, 1'b0);
		add_sample(-64'sd1, 1'b0);
		add_sample(64'sh4000_0000_0000_0000, 1'b0);
		add_sample(-64'sd5, 1'b0);
		// The rotation now points at channel 5, beyond a count of three.
		add_write(REG_CHANNEL_COUNT, 48'd3);
		add_sample(64'sd77, 1'b0);
		add_write(REG_CHANNEL_COUNT, 48'd15);
		add_sample(64'sd100, 1'b0);
		add_sample(-64'sd100, 1'b0);
		// Shifts 0, 1, 8, 16, 32, 40, 48 and 63 on channels 0 to 7.
		add_write(REG_CHANNEL_SHIFTS, 48'hFF0A_2040_8040);
		add_sample(SMP_MAX, 1'b1);
		add_sample(64'sh7FFF_FFFF, 1'b0);
		add_sample(SMP_MIN, 1'b0);
		add_sample(-64'sd1, 1'b0);

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r]) begin
			if (stim_rows[r].kind == ROW_WRITE) begin
				drain_results();
				write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_val);
			end else begin
				send_sample(stim_rows[r].smp, stim_rows[r].sob, stim_rows[r].has_exp,
					stim_rows[r].exp_word);
			end
		end

		for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
			drain_results();
			case (blk % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase

			// Upper data bits are random; each register keeps only its own field.
			val = rand_cfg();
			val[1:0] = 2'($urandom_range(3));
			write_reg(REG_SAMPLE_WIDTH, val);
			write_reg(REG_UNSIGNED_SAMPLES, rand_cfg());
			write_reg(REG_BIG_ENDIAN, rand_cfg());
			val = rand_cfg();
			case ($urandom_range(5))
				0: val[3:0] = 4'd0;
				1: val[3:0] = 4'd1;
				2: val[3:0] = 4'd8;
				3: val[3:0] = 4'd15;
				default: val[3:0] = 4'($urandom_range(1, 8));
			endcase
			write_reg(REG_CHANNEL_COUNT, val);
			case ($urandom_range(3))
				0: val = '0;
				1: val = '1;
				default: val = rand_cfg();
			endcase
			write_reg(REG_CHANNEL_SHIFTS, val);
			write_reg(3'($urandom_range(REG_CHANNEL_SHIFTS + 1, REG_UNUSED)), rand_cfg());

			repeat (BLOCK_ITEMS)
				send_sample(rand_sample(), ($urandom_range(11) == 0), 1'b0, '0);
		end

		drain_results();
		repeat (PIPE_LATENCY + 4)
			@(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
